FILE: rtl/ws2812cs_pkg.sv
// Package for the single-wire LED colour serialiser.
// Holds the timing register bundle, register indexes, colour codes and the colour table.
// No dependencies.
`default_nettype none

package ws2812cs_pkg;

  localparam int CFG_ADDR_W = 8;
  localparam int TICK_REG_W = 8;
  localparam int CODE_W     = 3;
  localparam int GRB_W      = 24;
  localparam int BIT_CNT_W  = 5;
  localparam int PIX_CNT_W  = 2;

  localparam logic [BIT_CNT_W-1:0] WORD_BITS = BIT_CNT_W'(GRB_W);

  // Register indexes on the configuration channel.
  localparam logic [CFG_ADDR_W-1:0] REG_ZERO_HIGH = 8'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_ZERO_LOW  = 8'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_ONE_HIGH  = 8'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_ONE_LOW   = 8'd3;

  localparam logic [TICK_REG_W-1:0] RST_ZERO_HIGH = 8'd22;
  localparam logic [TICK_REG_W-1:0] RST_ZERO_LOW  = 8'd50;
  localparam logic [TICK_REG_W-1:0] RST_ONE_HIGH  = 8'd52;
  localparam logic [TICK_REG_W-1:0] RST_ONE_LOW   = 8'd22;

  localparam logic [CODE_W-1:0] COLOR_BLACK  = 3'd0;
  localparam logic [CODE_W-1:0] COLOR_RED    = 3'd1;
  localparam logic [CODE_W-1:0] COLOR_GREEN  = 3'd2;
  localparam logic [CODE_W-1:0] COLOR_BLUE   = 3'd3;
  localparam logic [CODE_W-1:0] COLOR_YELLOW = 3'd4;
  localparam logic [CODE_W-1:0] COLOR_PURPLE = 3'd5;
  localparam logic [CODE_W-1:0] COLOR_CYAN   = 3'd6;
  localparam logic [CODE_W-1:0] COLOR_WHITE  = 3'd7;

  typedef struct packed {
    logic [TICK_REG_W-1:0] zero_high;
    logic [TICK_REG_W-1:0] zero_low;
    logic [TICK_REG_W-1:0] one_high;
    logic [TICK_REG_W-1:0] one_low;
  } timing_t;

  // Colour code to green-red-blue word, green in the top byte.
  function automatic logic [GRB_W-1:0] grb_word(input logic [CODE_W-1:0] code);
    logic [GRB_W-1:0] w;
    unique case (code)
      COLOR_BLACK:  w = 24'h000000;
      COLOR_RED:    w = 24'h00FF00;
      COLOR_GREEN:  w = 24'hFF0000;
      COLOR_BLUE:   w = 24'h0000FF;
      COLOR_YELLOW: w = 24'hFFFF00;
      COLOR_PURPLE: w = 24'h00FFFF;
      COLOR_CYAN:   w = 24'hFF00FF;
      COLOR_WHITE:  w = 24'hFFFFFF;
      default:      w = 24'h000000;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/ws2812_color_serializer.sv
// Single-wire LED colour serialiser, one line level per timing tick.
// Depends on ws2812cs_pkg and ws2812cs_cfg_regs.
//
// Usage: every transaction on the in_ channel is one timing tick. in_tuser
// flags a colour request and in_tdata carries its 3-bit colour code. For each
// tick one transaction leaves on the out_ channel with the line level, a busy
// flag and a flag for a request dropped because a frame was still going out.
// An idle request for a new colour starts a 24-bit green-red-blue frame (red
// is sent twice) on that same tick; each bit is high then low for the tick
// counts held in the four timing registers on the cfg_ channel.
// The result of an input transaction is registered and is shown in the cycle
// after it is taken; one tick is taken every cycle while the receiver does not
// stall, as the serialiser state and the result register update in the same
// clock edge. in_tready is high whenever the result register is empty or is
// being emptied, so a stalled receiver stalls the input one for one and no tick
// is lost. Timing registers should be written while no tick is pending.
// Reset (rst_n low, synchronous) empties the result register, idles the line,
// restores the default tick counts and sets the last colour to black.
`default_nettype none

module ws2812_color_serializer #(
  parameter int TICK_COUNT_WIDTH = 8
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // Input ticks.
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  input  wire logic [7:0]                         in_tdata,  // [2:0] color_code
  input  wire logic                               in_tuser,  // [0] req_valid
  // Results.
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  output logic [7:0]                              out_tdata, // [0] line_level,
                                                             // [1] busy_res,
                                                             // [2] req_dropped
  // Configuration.
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [ws2812cs_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [ws2812cs_pkg::TICK_REG_W-1:0] cfg_data
);

  localparam int TW = TICK_COUNT_WIDTH;
  // Duration width: holds both a register value and the cap 2^TW.
  localparam int DW = ((TW > ws2812cs_pkg::TICK_REG_W) ? TW : ws2812cs_pkg::TICK_REG_W) + 1;
  localparam logic [DW-1:0] DUR_CAP = DW'(1) << TW;

  ws2812cs_pkg::timing_t timing;

  ws2812cs_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .timing    (timing)
  );

  // Serialiser state.
  logic [ws2812cs_pkg::CODE_W-1:0]    last_color_r, last_color_nxt;
  logic [ws2812cs_pkg::GRB_W-1:0]     shift_word_r, shift_word_nxt;
  logic [ws2812cs_pkg::BIT_CNT_W-1:0] bit_left_r, bit_left_nxt;
  logic [ws2812cs_pkg::PIX_CNT_W-1:0] pixels_left_r, pixels_left_nxt;
  logic                               low_phase_r, low_phase_nxt;
  logic [TW-1:0]                      phase_ticks_r, phase_ticks_nxt;
  logic                               sending_r, sending_nxt;

  // Result register.
  logic       out_valid_r, out_valid_nxt;
  logic [2:0] out_bits_r, out_bits_nxt;

  logic                             accept;
  logic                             req;
  logic [ws2812cs_pkg::CODE_W-1:0]  code;
  logic                             start;
  logic [ws2812cs_pkg::TICK_REG_W-1:0] reg_sel;
  logic [DW-1:0]                    dur;
  logic [DW-1:0]                    phase_inc;
  logic [ws2812cs_pkg::BIT_CNT_W-1:0] bit_dec;
  logic                             level, busy, dropped;

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign req       = in_tuser;
  assign code      = in_tdata[ws2812cs_pkg::CODE_W-1:0];

  always_comb begin
    dropped = req && sending_r;
    start   = req && !sending_r && (code != last_color_r);

    // State as seen after the request of this tick has been taken.
    last_color_nxt  = start ? code : last_color_r;
    shift_word_nxt  = start ? ws2812cs_pkg::grb_word(code) : shift_word_r;
    bit_left_nxt    = start ? ws2812cs_pkg::WORD_BITS : bit_left_r;
    pixels_left_nxt = start ? ws2812cs_pkg::PIX_CNT_W'(code == ws2812cs_pkg::COLOR_RED)
                            : pixels_left_r;
    low_phase_nxt   = start ? 1'b0 : low_phase_r;
    phase_ticks_nxt = start ? '0 : phase_ticks_r;
    sending_nxt     = sending_r || start;

    if (low_phase_nxt) begin
      reg_sel = shift_word_nxt[ws2812cs_pkg::GRB_W-1] ? timing.one_low : timing.zero_low;
    end else begin
      reg_sel = shift_word_nxt[ws2812cs_pkg::GRB_W-1] ? timing.one_high : timing.zero_high;
    end
    // A count of zero means one tick; a count above the counter range is capped.
    dur = DW'(reg_sel);
    if (dur == '0) begin
      dur = DW'(1);
    end else if (dur > DUR_CAP) begin
      dur = DUR_CAP;
    end
    phase_inc = DW'(phase_ticks_nxt) + DW'(1);
    bit_dec   = (bit_left_nxt != '0) ? (bit_left_nxt - ws2812cs_pkg::BIT_CNT_W'(1))
                                     : bit_left_nxt;

    level = 1'b0;
    busy  = 1'b0;
    if (sending_nxt) begin
      busy  = 1'b1;
      level = !low_phase_nxt;
      if (phase_inc >= dur) begin
        phase_ticks_nxt = '0;
        if (!low_phase_nxt) begin
          low_phase_nxt = 1'b1;
        end else begin
          low_phase_nxt  = 1'b0;
          shift_word_nxt = {shift_word_nxt[ws2812cs_pkg::GRB_W-2:0], 1'b0};
          bit_left_nxt   = bit_dec;
          if (bit_dec == '0) begin
            if (pixels_left_nxt != '0) begin
              pixels_left_nxt = pixels_left_nxt - ws2812cs_pkg::PIX_CNT_W'(1);
              shift_word_nxt  = ws2812cs_pkg::grb_word(last_color_nxt);
              bit_left_nxt    = ws2812cs_pkg::WORD_BITS;
            end else begin
              sending_nxt = 1'b0;
            end
          end
        end
      end else begin
        // Cannot wrap: the phase ends before the count reaches 2^TW.
        phase_ticks_nxt = phase_ticks_nxt + TW'(1);
      end
    end

    out_valid_nxt = accept ? 1'b1 : (out_valid_r && !out_tready);
    out_bits_nxt  = accept ? {dropped, busy, level} : out_bits_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_color_r  <= ws2812cs_pkg::COLOR_BLACK;
      shift_word_r  <= '0;
      bit_left_r    <= '0;
      pixels_left_r <= '0;
      low_phase_r   <= 1'b0;
      phase_ticks_r <= '0;
      sending_r     <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        last_color_r  <= last_color_nxt;
        shift_word_r  <= shift_word_nxt;
        bit_left_r    <= bit_left_nxt;
        pixels_left_r <= pixels_left_nxt;
        low_phase_r   <= low_phase_nxt;
        phase_ticks_r <= phase_ticks_nxt;
        sending_r     <= sending_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_bits_r <= out_bits_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_bits_r};

endmodule

`default_nettype wire

FILE: rtl/ws2812cs_cfg_regs.sv
// Timing register file of the LED colour serialiser.
// Four 8-bit tick counts written over the configuration channel.
// Depends on ws2812cs_pkg.
`default_nettype none

module ws2812cs_cfg_regs (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [ws2812cs_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [ws2812cs_pkg::TICK_REG_W-1:0] cfg_data,
  output ws2812cs_pkg::timing_t                   timing
);

  ws2812cs_pkg::timing_t timing_r;
  ws2812cs_pkg::timing_t timing_nxt;

  assign cfg_ready = 1'b1;
  assign timing    = timing_r;

  always_comb begin
    timing_nxt = timing_r;
    if (cfg_valid) begin
      // Unknown indexes are ignored.
      priority case (cfg_addr)
        ws2812cs_pkg::REG_ZERO_HIGH: timing_nxt.zero_high = cfg_data;
        ws2812cs_pkg::REG_ZERO_LOW:  timing_nxt.zero_low  = cfg_data;
        ws2812cs_pkg::REG_ONE_HIGH:  timing_nxt.one_high  = cfg_data;
        ws2812cs_pkg::REG_ONE_LOW:   timing_nxt.one_low   = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timing_r.zero_high <= ws2812cs_pkg::RST_ZERO_HIGH;
      timing_r.zero_low  <= ws2812cs_pkg::RST_ZERO_LOW;
      timing_r.one_high  <= ws2812cs_pkg::RST_ONE_HIGH;
      timing_r.one_low   <= ws2812cs_pkg::RST_ONE_LOW;
    end else begin
      timing_r <= timing_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/ws2812cs_checker.sv
// Port checker for the LED colour serialiser, bound to the top level.
// Watches the in_ and out_ stream channels; no package dependency.
`default_nettype none

module ws2812cs_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_tvalid,
  input wire logic       in_tready,
  input wire logic       out_tvalid,
  input wire logic       out_tready,
  input wire logic [7:0] out_tdata
);

  // Each accepted tick yields a result on the next cycle.
  a_tick_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("accepted tick produced no result");

  // A dropped request can only occur while a frame is going out.
  a_drop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2] |-> out_tdata[1])
    else $error("request dropped while idle");

  // The line rests low when no frame is being sent.
  a_idle_low: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[1] |-> !out_tdata[0])
    else $error("line high while idle");

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

endmodule

bind ws2812_color_serializer ws2812cs_checker u_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
